FILE: rtl/hxu_pkg.sv
// Shared types and constants for the backslash-hex unescaper.
// No dependencies; every module of the block imports this package.
package hxu_pkg;

   // Character and byte codes used by the decoder and the EF BE filter.
   localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;
   localparam logic [7:0] X_CHAR         = 8'h78;
   localparam logic [7:0] DIGIT_0_CHAR   = 8'h30;
   localparam logic [7:0] DIGIT_9_CHAR   = 8'h39;
   localparam logic [7:0] LOWER_A_CHAR   = 8'h61;
   localparam logic [7:0] LOWER_F_CHAR   = 8'h66;
   localparam logic [7:0] UPPER_A_CHAR   = 8'h41;
   localparam logic [7:0] UPPER_F_CHAR   = 8'h46;
   localparam logic [7:0] DROP_HEAD_BYTE = 8'hEF;
   localparam logic [7:0] DROP_TAIL_BYTE = 8'hBE;

   // Most results one request can produce.
   localparam int MAX_RESULTS = 4;

   // One classified request: the result bytes it produces, in order.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] data;   // result bytes, slot 0 first
      logic [2:0]                  count;  // number of results, 1 to 4
      logic                        bare;   // single end marker without a byte
      logic                        last;   // request carried the final byte
   } entry_type;

endpackage

FILE: rtl/hxu_front.sv
// Front end: accepts requests, runs the escape decoder and the EF BE filter,
// and writes the resulting byte list into the queue. Depends on hxu_pkg.
module hxu_front
   import hxu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  logic [7:0] req_in_byte,
   input  logic      req_final_byte,
   output logic      push_valid,
   output entry_type push_entry,
   input  logic      push_ready
);

   typedef enum logic [1:0] {
      MODE_PLAIN,
      MODE_BACKSLASH,
      MODE_X,
      MODE_DIGIT
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic [7:0] first_digit_ff, first_digit_in;
   logic       held_ef_ff, held_ef_in;

   logic            accept;
   logic [2:0][7:0] dec_byte;
   logic [1:0]      dec_cnt;
   logic            is_hex;

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      // Digits carry their value in the low nibble; letters are offset by nine.
      return (c <= DIGIT_9_CHAR) ? c[3:0] : c[3:0] + 4'd9;
   endfunction

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   assign is_hex = (req_in_byte >= DIGIT_0_CHAR && req_in_byte <= DIGIT_9_CHAR) ||
                   (req_in_byte >= LOWER_A_CHAR && req_in_byte <= LOWER_F_CHAR) ||
                   (req_in_byte >= UPPER_A_CHAR && req_in_byte <= UPPER_F_CHAR);

   // Escape decoder: up to three decoded bytes per request.
   always_comb begin
      mode_in        = mode_ff;
      first_digit_in = first_digit_ff;
      dec_byte       = '0;
      dec_cnt        = 2'd0;
      case (mode_ff)
         MODE_PLAIN: begin
            if (req_in_byte == BACKSLASH_CHAR) begin
               mode_in = MODE_BACKSLASH;
            end else begin
               dec_byte[0] = req_in_byte;
               dec_cnt     = 2'd1;
            end
         end
         MODE_BACKSLASH: begin
            if (req_in_byte == X_CHAR) begin
               mode_in = MODE_X;
            end else begin
               dec_byte[0] = BACKSLASH_CHAR;
               dec_byte[1] = req_in_byte;
               dec_cnt     = 2'd2;
               mode_in     = MODE_PLAIN;
            end
         end
         MODE_X: begin
            if (is_hex) begin
               first_digit_in = req_in_byte;
               mode_in        = MODE_DIGIT;
            end else begin
               dec_byte[0] = BACKSLASH_CHAR;
               dec_byte[1] = X_CHAR;
               dec_cnt     = 2'd2;
               mode_in     = MODE_PLAIN;
            end
         end
         MODE_DIGIT: begin
            if (is_hex) begin
               dec_byte[0] = {hex_nibble(first_digit_ff), hex_nibble(req_in_byte)};
               dec_cnt     = 2'd1;
            end else begin
               // The offending byte is dropped.
               dec_byte[0] = BACKSLASH_CHAR;
               dec_byte[1] = X_CHAR;
               dec_byte[2] = first_digit_ff;
               dec_cnt     = 2'd3;
            end
            mode_in = MODE_PLAIN;
         end
         default: begin
            mode_in = MODE_PLAIN;
         end
      endcase
      if (req_final_byte) begin
         mode_in = MODE_PLAIN;
      end
   end

   // EF BE filter over the decoded bytes, then end-of-string handling.
   always_comb begin
      logic       held;
      logic       drop;
      logic [2:0] ocnt;
      logic [MAX_RESULTS-1:0][7:0] obytes;
      held   = held_ef_ff;
      ocnt   = 3'd0;
      obytes = '0;
      drop   = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (dec_cnt > 2'(i)) begin
            drop = 1'b0;
            if (held) begin
               held = 1'b0;
               if (dec_byte[i] == DROP_TAIL_BYTE) begin
                  drop = 1'b1;
               end else begin
                  obytes[ocnt[1:0]] = DROP_HEAD_BYTE;
                  ocnt              = ocnt + 3'd1;
               end
            end
            if (!drop) begin
               if (dec_byte[i] == DROP_HEAD_BYTE) begin
                  held = 1'b1;
               end else begin
                  obytes[ocnt[1:0]] = dec_byte[i];
                  ocnt              = ocnt + 3'd1;
               end
            end
         end
      end
      push_entry.bare = 1'b0;
      if (req_final_byte) begin
         if (held) begin
            obytes[ocnt[1:0]] = DROP_HEAD_BYTE;
            ocnt              = ocnt + 3'd1;
         end
         held = 1'b0;
         if (ocnt == 3'd0) begin
            push_entry.bare = 1'b1;
            ocnt            = 3'd1;
         end
      end
      push_entry.data  = obytes;
      push_entry.count = ocnt;
      push_entry.last  = req_final_byte;
      held_ef_in       = held;
      push_valid       = accept && (ocnt != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_PLAIN;
         held_ef_ff <= 1'b0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         held_ef_ff <= held_ef_in;
      end
      if (accept) begin
         first_digit_ff <= first_digit_in;
      end
   end

endmodule

FILE: rtl/hxu_queue.sv
// Two-entry queue of classified requests between front end and back end.
// Depends on hxu_pkg for the entry type.
module hxu_queue
   import hxu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_entry
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/hxu_back.sv
// Back end: walks the queue head one result per cycle into the output register,
// unless the response port stalls. Depends on hxu_pkg for the entry type.
module hxu_back
   import hxu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  entry_type  pop_entry,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_end_of_output
);

   logic [1:0] index_ff, index_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff;
   logic       byte_valid_ff;
   logic       end_ff;
   logic       load;
   logic       at_last;

   assign load    = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign at_last = ({1'b0, index_ff} == (pop_entry.count - 3'd1));
   assign pop_ready = load && at_last;

   always_comb begin
      index_in = index_ff;
      if (load) begin
         index_in = at_last ? 2'd0 : index_ff + 2'd1;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         out_byte_ff   <= pop_entry.data[index_ff];
         byte_valid_ff <= !pop_entry.bare;
         end_ff        <= pop_entry.last && at_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_byte_valid    = byte_valid_ff;
   assign rsp_end_of_output = end_ff;

endmodule

FILE: rtl/hex_escape_unescaper_top.sv
// Backslash-hex unescaper top level: front end, two-entry queue, back end.
// The first result of a request is written into the queue on the edge that accepts
// the request, then loaded into the output register that drives the response port.
// Throughput: one request per cycle while each request yields at most one result and
// the response port is not stalled; a request's results (up to four) go out in turn.
// Reset (synchronous, active high) returns the decoder to plain text with nothing held.
// Depends on hxu_pkg, hxu_front, hxu_queue and hxu_back.
module hex_escape_unescaper_top
   import hxu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_end_of_output
);

   // The front end decodes each request and filters EF BE pairs right away,
   // so every queue entry already lists its final result bytes. Requests that
   // produce nothing (an escape still in progress, a held EF) write no entry.
   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;

   // The back end pops an entry only after its last result has been loaded
   // into the output register, so the queue lets the front keep accepting
   // while a long failed escape is drained.
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_entry;

   hxu_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_final_byte (req_final_byte),
      .push_valid     (push_valid),
      .push_entry     (push_entry),
      .push_ready     (push_ready)
   );

   hxu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   hxu_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_entry         (pop_entry),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_end_of_output (rsp_end_of_output)
   );

`ifndef SYNTH
   // A bare end marker only ever closes a string.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> rsp_end_of_output)
      else $error("bare result without end of output");

   // A final request always leaves an entry in the queue.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_final_byte) |=> pop_valid)
      else $error("final request produced no queue entry");

   // Every queue entry carries between one and four results.
   assert property (@(posedge clock) disable iff (reset)
      pop_valid |-> (pop_entry.count != 3'd0 && pop_entry.count <= 3'd4))
      else $error("queue entry with bad result count");
`endif

endmodule
